// ----- hdl/sha256_stream_hasher_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SHS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SHS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sha256sh_pkg.sv -----
package sha256sh_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned WinLen  = 16;
  localparam int unsigned NumRnd  = 64;
  localparam int unsigned NumHash = 8;

  localparam logic [NumHash-1:0][WordW-1:0] HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [WordW-1:0] PadMarker = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_WAIT,
    ST_OUT
  } top_state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ROUND,
    CS_ADD
  } core_state_e;

  // Commands from the sequencer to the compression engine.
  typedef struct packed {
    logic push;   // shift one word into the schedule window
    logic start;  // begin a 64-round compression
    logic init;   // return the chaining value to the initial hash
  } core_ctl_t;

  function automatic logic [WordW-1:0] round_const(input logic [5:0] t);
    logic [WordW-1:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// ----- hdl/sha256sh_core.sv -----
module sha256sh_core import sha256sh_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  core_ctl_t                     ctl_i,
  input  logic [WordW-1:0]              push_word_i,
  output logic                          busy_o,
  output logic [NumHash-1:0][WordW-1:0] hash_o
);

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  core_state_e state_q, state_d;
  logic [5:0]                        rnd_q, rnd_d;
  logic [WinLen-1:0][WordW-1:0]      win_q, win_d;
  logic [NumHash-1:0][WordW-1:0]     vars_q, vars_d;
  logic [NumHash-1:0][WordW-1:0]     hash_q, hash_d;

  logic round_en, add_en;
  logic [WordW-1:0] w_next, sig0, sig1, bsig0, bsig1, ch, maj, t1, t2;

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE:  if (ctl_i.start) state_d = CS_ROUND;
      CS_ROUND: if (rnd_q == 6'(NumRnd - 1)) state_d = CS_ADD;
      CS_ADD:   state_d = CS_IDLE;
      default:  state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    round_en = 1'b0;
    add_en   = 1'b0;
    busy_o   = 1'b1;
    case (state_q)
      CS_IDLE:  busy_o   = 1'b0;
      CS_ROUND: round_en = 1'b1;
      CS_ADD:   add_en   = 1'b1;
      default:  busy_o   = 1'b0;
    endcase
  end

  // The window holds W[t] .. W[t+15]; each round retires W[t] and appends W[t+16].
  always_comb begin
    sig0   = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
    sig1   = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
    w_next = win_q[0] + sig0 + win_q[9] + sig1;

    bsig1 = rotr(vars_q[4], 6) ^ rotr(vars_q[4], 11) ^ rotr(vars_q[4], 25);
    ch    = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
    t1    = vars_q[7] + bsig1 + ch + round_const(rnd_q) + win_q[0];
    bsig0 = rotr(vars_q[0], 2) ^ rotr(vars_q[0], 13) ^ rotr(vars_q[0], 22);
    maj   = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
    t2    = bsig0 + maj;
  end

  always_comb begin
    win_d = win_q;
    if (ctl_i.push || round_en) begin
      for (int i = 0; i < WinLen - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[WinLen-1] = round_en ? w_next : push_word_i;
    end

    vars_d = vars_q;
    if (ctl_i.start) begin
      vars_d = hash_q;
    end else if (round_en) begin
      vars_d[7] = vars_q[6];
      vars_d[6] = vars_q[5];
      vars_d[5] = vars_q[4];
      vars_d[4] = vars_q[3] + t1;
      vars_d[3] = vars_q[2];
      vars_d[2] = vars_q[1];
      vars_d[1] = vars_q[0];
      vars_d[0] = t1 + t2;
    end

    hash_d = hash_q;
    if (ctl_i.init) begin
      hash_d = HashInit;
    end else if (add_en) begin
      for (int j = 0; j < NumHash; j++) begin
        hash_d[j] = hash_q[j] + vars_q[j];
      end
    end

    rnd_d = ctl_i.start ? '0 : (round_en ? rnd_q + 6'd1 : rnd_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      rnd_q   <= '0;
      hash_q  <= HashInit;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      hash_q  <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    vars_q <= vars_d;
  end

  assign hash_o = hash_q;

endmodule

// ----- hdl/sha256_stream_hasher.sv -----
// SHA-256 over a stream of big-endian 32-bit words. Every word but the last
// carries four bytes; the word with message_end_i carries 0 to 4 bytes in its
// top bytes (counts above four are taken as four). The block pads the message,
// then presents the eight digest words in order (word_index_o 0..7,
// digest_done_o on the last) and starts over with a fresh message. Input
// words are taken one per cycle until sixteen fill a block; the sixteenth
// word then starts a compression in the single round unit, which runs one
// round per cycle, and in_ready_o stays low until that compression is done.
// After the last word, padding is written one word per cycle, followed by one
// or two compressions, and the digest words are offered one per cycle while
// out_ready_i is high; in_ready_o is low throughout.
module sha256_stream_hasher import sha256sh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        message_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        digest_done_o
);

  top_state_e state_q, state_d;
  logic [3:0]  cnt_q;
  logic [63:0] bits_q;
  logic        fin_q, mark_q, hi_q, lo_q;
  logic [2:0]  idx_q;

  core_ctl_t                     ctl;
  logic [WordW-1:0]              push_word;
  logic                          core_busy;
  logic [NumHash-1:0][WordW-1:0] hash;

  logic       in_acc, out_acc;
  logic [2:0] nb_sat;
  logic [WordW-1:0] last_word;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign nb_sat  = (valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i;

  // Final item: keep the valid leading bytes and place the marker right after; a full word gets it in the next word.
  always_comb begin
    case (nb_sat)
      3'd0:    last_word = PadMarker;
      3'd1:    last_word = {data_word_i[31:24], 24'h80_0000};
      3'd2:    last_word = {data_word_i[31:16], 16'h8000};
      3'd3:    last_word = {data_word_i[31:8], 8'h80};
      default: last_word = data_word_i;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cnt_q == 4'd15)     state_d = ST_WAIT;
          else if (message_end_i) state_d = ST_PAD;
        end
      end
      ST_PAD:  if (cnt_q == 4'd15) state_d = ST_WAIT;
      ST_WAIT: begin
        if (!core_busy) begin
          if (lo_q)       state_d = ST_OUT;
          else if (fin_q) state_d = ST_PAD;
          else            state_d = ST_IDLE;
        end
      end
      ST_OUT:  if (out_acc && idx_q == 3'd7) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ctl         = '0;
    push_word   = data_word_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ctl.push   = in_acc;
        if (message_end_i) push_word = last_word;
      end
      ST_PAD: begin
        ctl.push = 1'b1;
        if (mark_q)              push_word = PadMarker;
        else if (hi_q)           push_word = bits_q[31:0];
        else if (cnt_q == 4'd14) push_word = bits_q[63:32];
        else                     push_word = '0;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        ctl.init    = out_acc && (idx_q == 3'd7);
      end
      default: ;
    endcase
    ctl.start = ctl.push && (cnt_q == 4'd15);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      bits_q  <= '0;
      fin_q   <= 1'b0;
      mark_q  <= 1'b0;
      hi_q    <= 1'b0;
      lo_q    <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (ctl.push) cnt_q <= cnt_q + 4'd1;
      if (in_acc) begin
        bits_q <= bits_q + (message_end_i ? {58'd0, nb_sat, 3'd0} : 64'd32);
        if (message_end_i) begin
          fin_q  <= 1'b1;
          mark_q <= (nb_sat == 3'd4);
        end
      end
      if (state_q == ST_PAD) begin
        if (mark_q)              mark_q <= 1'b0;
        else if (hi_q)           lo_q   <= 1'b1;
        else if (cnt_q == 4'd14) hi_q   <= 1'b1;
      end
      if (out_acc) idx_q <= idx_q + 3'd1;
      if (ctl.init) begin
        bits_q <= '0;
        fin_q  <= 1'b0;
        hi_q   <= 1'b0;
        lo_q   <= 1'b0;
      end
    end
  end

  sha256sh_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .push_word_i (push_word),
    .busy_o      (core_busy),
    .hash_o      (hash)
  );

  assign digest_word_o = hash[idx_q];
  assign word_index_o  = idx_q;
  assign digest_done_o = (idx_q == 3'd7);

endmodule

// ----- hdl/sha256sh_checker.sv -----
`include "sha256_stream_hasher_macros.svh"

module sha256sh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [31:0] data_word_i,
  input logic [2:0]  valid_bytes_i,
  input logic        message_end_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        digest_done_o
);

  // The block never takes an item while it is still handing out a digest.
  `SHS_ASSERT_NOW(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o, "ready while digest pending")

  `SHS_ASSERT_NOW(a_done_last, clk_i, rst_ni, out_valid_o, digest_done_o == (word_index_o == 3'd7), "digest_done not on last word")

  // Digest words come out back to back in index order.
  `SHS_ASSERT_NEXT(a_idx_step, clk_i, rst_ni, out_valid_o && out_ready_i && !digest_done_o, out_valid_o && word_index_o == $past(word_index_o) + 3'd1, "digest word skipped")

  // Padding follows the final item, so nothing is taken or shown next cycle.
  `SHS_ASSERT_NEXT(a_pad_busy, clk_i, rst_ni, in_valid_i && in_ready_o && message_end_i, !in_ready_o && !out_valid_o, "no padding after final item")

  `SHS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(digest_word_o), "stalled digest word changed")

endmodule

bind sha256_stream_hasher sha256sh_checker u_checker (.*);

// ----- tb/sv/sha256_stream_hasher_tb.sv -----
`timescale 1ns / 100ps

module sha256_stream_hasher_tb;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldCycles  = 600;

  // Written in natural order; the ascending range makes index 0 the first entry.
  localparam logic [0:63][31:0] RoundK = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] HashStart = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        done;
  } digest_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] data_word_i = '0;
  logic [2:0]  valid_bytes_i = '0;
  logic        message_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        digest_done_o;

  // Digest predictor state.
  logic [31:0] chain_h [8];
  logic [31:0] block_w [16];
  int unsigned blk_count;
  logic [63:0] msg_bit_len;

  digest_item_t digest_q [$];
  digest_item_t want;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  int unsigned items_sent     = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;

  sha256_stream_hasher DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_word_i   (data_word_i),
    .valid_bytes_i (valid_bytes_i),
    .message_end_i (message_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .digest_done_o (digest_done_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void clear_message();
    for (int j = 0; j < 8; j++) chain_h[j] = HashStart[j];
    blk_count   = 0;
    msg_bit_len = '0;
  endfunction

  function automatic void hash_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] wt, s0x, s1x, t1, t2;
    w = block_w;
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        s0x = rotr(w[(t - 15) & 15], 7) ^ rotr(w[(t - 15) & 15], 18) ^ (w[(t - 15) & 15] >> 3);
        s1x = rotr(w[(t - 2) & 15], 17) ^ rotr(w[(t - 2) & 15], 19) ^ (w[(t - 2) & 15] >> 10);
        wt = w[t & 15] + s0x + w[(t - 7) & 15] + s1x;
        w[t & 15] = wt;
      end
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + RoundK[t] + wt;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endfunction

  function automatic void push_block_word(input logic [31:0] w);
    block_w[blk_count] = w;
    blk_count++;
    if (blk_count == 16) begin
      hash_block();
      blk_count = 0;
    end
  endfunction

  // Updates the predictor for one accepted item and queues the digest on the last one.
  function automatic void absorb_item(input logic [31:0] d, input logic [2:0] nb,
                                      input logic last);
    int unsigned n;
    logic [31:0] keep;
    digest_item_t item;
    if (!last) begin
      msg_bit_len += 64'd32;
      push_block_word(d);
      return;
    end
    n = (nb > 3'd4) ? 4 : nb;
    msg_bit_len += 64'(n * 8);
    if (n == 4) begin
      push_block_word(d);
      push_block_word(32'h8000_0000);
    end else begin
      keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
      push_block_word((d & keep) | (32'h80 << (24 - 8 * n)));
    end
    while (blk_count != 14) push_block_word(32'h0);
    push_block_word(msg_bit_len[63:32]);
    push_block_word(msg_bit_len[31:0]);
    for (int j = 0; j < 8; j++) begin
      item.word  = chain_h[j];
      item.index = 3'(j);
      item.done  = (j == 7);
      digest_q.push_back(item);
    end
    clear_message();
  endfunction

  // Leaves valid high after acceptance so back-to-back items need no extra edge.
  task automatic send_word(input logic [31:0] d, input logic [2:0] nb, input logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_word_i   <= d;
    valid_bytes_i <= nb;
    message_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_item(d, nb, last);
    items_sent++;
  endtask

  task automatic send_message(input int unsigned n_full, input logic [31:0] tail_data,
                              input logic [2:0] tail_bytes);
    for (int unsigned i = 0; i < n_full; i++) send_word($urandom, 3'($urandom_range(7)), 1'b0);
    send_word(tail_data, tail_bytes, 1'b1);
  endtask

  // Short final words: empty, partial with junk below the valid bytes, full,
  // and byte counts above four.
  task automatic test_final_word_cases();
    send_message(0, $urandom, 3'd0);
    send_message(0, 32'h6162_63ff, 3'd3);
    send_message(0, 32'hffff_ffff, 3'd4);
    send_message(0, 32'h00ff_ffff, 3'd1);
    send_message(0, 32'hffff_ffff, 3'd2);
    send_message(1, 32'h0000_0000, 3'd5);
    send_message(0, 32'hffff_ffff, 3'd6);
    send_message(0, $urandom, 3'd7);
  endtask

  // Fourteen full words leave no room for the length, so padding spills into a second block.
  task automatic test_two_block_padding();
    send_message(14, $urandom, 3'd0);
  endtask

  task automatic test_random_messages(input int unsigned budget, input int unsigned idle_pct,
                                      input int unsigned stall_pct);
    int unsigned stop_at;
    int unsigned sel;
    int unsigned len;
    logic [2:0] nb;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      sel = $urandom_range(19);
      if (sel < 15) len = $urandom_range(6);
      else if (sel < 19) len = $urandom_range(20, 7);
      else len = $urandom_range(40, 21);
      nb = ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
      send_message(len, $urandom, nb);
    end
  endtask

  // The receiver holds off while messages keep coming, so the block must stall its input.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HoldCycles;
    for (int k = 0; k < 4; k++) send_message($urandom_range(4), $urandom, 3'($urandom_range(4)));
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digest_q.size() == 0) begin
        $error("digest_word: none expected, got %h (word_index %0d)",
               digest_word_o, word_index_o);
        error_count++;
      end else begin
        want = digest_q.pop_front();
        if (digest_word_o !== want.word) begin
          $error("digest_word: expected %h, got %h", want.word, digest_word_o);
          error_count++;
        end
        if (word_index_o !== want.index) begin
          $error("word_index: expected %0d, got %0d", want.index, word_index_o);
          error_count++;
        end
        if (digest_done_o !== want.done) begin
          $error("digest_done: expected %0b, got %0b", want.done, digest_done_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("sha256_stream_hasher: mismatch");
      $finish;
    end
  end

  initial begin
    clear_message();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_final_word_cases();
    test_two_block_padding();
    test_random_messages(50, 0, 0);
    test_random_messages(40, 81, 0);
    test_random_messages(40, 0, 81);
    test_random_messages(40, 13, 13);
    test_output_backpressure();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("sha256_stream_hasher: match");
    end else begin
      $display("sha256_stream_hasher: mismatch");
    end
    $finish;
  end

endmodule
